// File: sv/scrolled_tilemap_pixel_renderer_assert.svh
// Assertion macros used by the checker file of the playfield renderer.
`ifndef SCROLLED_TILEMAP_PIXEL_RENDERER_ASSERT_SVH
`define SCROLLED_TILEMAP_PIXEL_RENDERER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STPR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define STPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/stpr_pkg.sv
// Package with the types, constants and helper functions of the playfield renderer.
package stpr_pkg;

    localparam int TILE_COUNT  = 512;
    localparam int MAP_SIDE    = 64;
    localparam int MAP_WORDS   = MAP_SIDE * MAP_SIDE;
    localparam int MAP_AW      = $clog2(MAP_WORDS);
    localparam int CODE_W      = $clog2(TILE_COUNT);
    localparam int CODE_SUM_W  = CODE_W + 1;
    localparam int PEN_ROWS    = TILE_COUNT * 8;
    localparam int PEN_AW      = $clog2(PEN_ROWS);
    localparam int PAL_DEPTH   = 512;
    localparam int PAL_AW      = $clog2(PAL_DEPTH);
    localparam int LOOKUP_SIZE = 256;
    localparam int OUT_DEPTH   = 8;
    localparam int OUT_AW      = $clog2(OUT_DEPTH);
    localparam int OUT_CW      = OUT_AW + 1;

    localparam logic [1:0] CMD_WR_MAP = 2'd0;
    localparam logic [1:0] CMD_WR_PAL = 2'd1;
    localparam logic [1:0] CMD_LOAD   = 2'd2;
    localparam logic [1:0] CMD_RENDER = 2'd3;

    localparam logic [1:0] CFG_SCROLL_X = 2'd0;
    localparam logic [1:0] CFG_SCROLL_Y = 2'd1;
    localparam logic [1:0] CFG_BANK     = 2'd2;

    localparam logic [PAL_AW-1:0] PAL_ORIGIN = PAL_AW'(32);

    typedef logic [CODE_W-1:0] t_code;
    typedef t_code t_code_tab [LOOKUP_SIZE];

    typedef struct packed {
        logic [23:0] rgb;
        logic [1:0]  pen;
    } t_result;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] idx;
        logic [2:0]  row;
        logic [15:0] data;
        logic [15:0] pens;
        logic        tile_ok;
        logic [2:0]  lo_x;
        logic [2:0]  lo_y;
    } t_stage1;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [PAL_AW-1:0] pal_idx;
        logic [15:0]       data;
        logic [2:0]        lo_x;
        logic [PAL_AW-1:0] base;
    } t_stage2;

    // Tile lookup table with fixed contents: each entry holds its own index.
    function automatic logic [15:0] f_lookup(input logic [7:0] idx);
        return {8'h00, idx};
    endfunction

    // (high byte * 256) mod TILE_COUNT for every high byte of a tile code.
    function automatic t_code_tab f_code_tab();
        t_code_tab tab;
        for (int i = 0; i < LOOKUP_SIZE; i++) begin
            tab[i] = CODE_W'((i * 256) % TILE_COUNT);
        end
        return tab;
    endfunction

    localparam t_code_tab CODE_TAB = f_code_tab();

    function automatic logic [7:0] f_boost(input logic [3:0] nib, input logic bright);
        logic [8:0] c;
        c = {1'b0, nib, nib};
        if (bright) begin
            c = c + 9'h022;
            if (c > 9'h0ff) begin
                c = 9'h0ff;
            end
        end
        return c[7:0];
    endfunction

endpackage

// File: sv/stpr_ram.sv
// Generic single-port synchronous RAM with registered read data.
module stpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// File: sv/stpr_out_fifo.sv
// Result FIFO that decouples the render pipeline from the output stall.
module stpr_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  stpr_pkg::t_result             i_push_data,
    input  logic                          i_pop,
    output logic                          o_valid,
    output stpr_pkg::t_result             o_data,
    output logic [stpr_pkg::OUT_CW-1:0]   o_count
);

    stpr_pkg::t_result               r_buf [stpr_pkg::OUT_DEPTH];
    logic [stpr_pkg::OUT_AW-1:0]     r_wr_ptr;
    logic [stpr_pkg::OUT_AW-1:0]     r_rd_ptr;
    logic [stpr_pkg::OUT_CW-1:0]     r_count;
    logic [stpr_pkg::OUT_CW-1:0]     n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + stpr_pkg::OUT_CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - stpr_pkg::OUT_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + stpr_pkg::OUT_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + stpr_pkg::OUT_AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: sv/scrolled_tilemap_pixel_renderer.sv
// Top level of the scrolled playfield pixel renderer.
//
// Commands arrive on the input channel (i_valid / o_stall); one beat carries
// one command. Tilemap writes, palette writes and tile row loads give no result.
// A render gives one beat on the output channel (o_valid / i_stall) holding
// the color and the pen. Scroll and tile bank are set through the register
// port (i_cfg_valid / o_cfg_ready), which is always ready.
// The tilemap, tile pen and palette memories are visited in that order, one
// pipeline stage each, so an item goes in every cycle while o_stall is low;
// a render's result is then written into the result FIFO and shown from it.
// Writes reach each memory in the same stage as reads, so command order holds.
// The output stall backs up into an eight-entry result FIFO; the input is
// stalled once renders in flight plus stored results fill it.
// After reset every memory is cleared, one row per cycle, while a counter
// walks all 4096 tile pen rows (TILE_COUNT * 8); o_stall is high meanwhile.
module scrolled_tilemap_pixel_renderer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [11:0] i_index,
    input  logic [2:0]  i_row,
    input  logic [15:0] i_data,
    input  logic [7:0]  i_plane_low,
    input  logic [7:0]  i_plane_high,
    input  logic [8:0]  i_pixel_x,
    input  logic [8:0]  i_pixel_y,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_pixel_rgb,
    output logic [1:0]  o_pixel_pen,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    logic [8:0]                    r_scroll_x;
    logic [8:0]                    r_scroll_y;
    logic                          r_bank;
    logic                          r_clr_busy;
    logic [stpr_pkg::PEN_AW-1:0]   r_clr_addr;

    logic                          r_p1_vld;
    stpr_pkg::t_stage1             r_p1;
    logic                          r_p2_vld;
    stpr_pkg::t_stage2             r_p2;
    logic                          r_p3_vld;
    logic [1:0]                    r_p3_pen;

    logic                          accept;
    logic [9:0]                    wx_sum;
    logic [9:0]                    wy_sum;
    logic [8:0]                    wx;
    logic [8:0]                    wy;
    logic [15:0]                   pen_row;
    logic [12:0]                   idx_ext;

    logic                          tm_we;
    logic [stpr_pkg::MAP_AW-1:0]   tm_addr;
    logic [15:0]                   tm_wdata;
    logic [15:0]                   tm_rdata;

    logic [15:0]                   look;
    logic [stpr_pkg::CODE_SUM_W-1:0] code_sum;
    logic [stpr_pkg::CODE_W-1:0]   code;
    logic [stpr_pkg::PAL_AW-1:0]   base;
    logic                          pen_we;
    logic [stpr_pkg::PEN_AW-1:0]   pen_addr;
    logic [15:0]                   pen_wdata;
    logic [15:0]                   pen_rdata;

    logic [1:0]                    pen;
    logic                          pal_we;
    logic [stpr_pkg::PAL_AW-1:0]   pal_addr;
    logic [23:0]                   pal_wdata;
    logic [23:0]                   pal_rdata;

    logic [1:0]                    inflight;
    logic [stpr_pkg::OUT_CW:0]     occupancy;
    logic [stpr_pkg::OUT_CW-1:0]   fifo_count;
    logic                          fifo_pop;
    stpr_pkg::t_result             push_data;
    stpr_pkg::t_result             head;

    assign inflight  = 2'(r_p1_vld && r_p1.cmd == stpr_pkg::CMD_RENDER)
                     + 2'(r_p2_vld && r_p2.cmd == stpr_pkg::CMD_RENDER)
                     + 2'(r_p3_vld);
    assign occupancy = (stpr_pkg::OUT_CW + 1)'(fifo_count) + (stpr_pkg::OUT_CW + 1)'(inflight);
    assign o_stall   = r_clr_busy || (occupancy >= (stpr_pkg::OUT_CW + 1)'(stpr_pkg::OUT_DEPTH));
    assign accept    = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_x <= '0;
            r_scroll_y <= '0;
            r_bank     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                stpr_pkg::CFG_SCROLL_X: r_scroll_x <= i_cfg_data;
                stpr_pkg::CFG_SCROLL_Y: r_scroll_y <= i_cfg_data;
                stpr_pkg::CFG_BANK:     r_bank     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + stpr_pkg::PEN_AW'(1);
            if (r_clr_addr == stpr_pkg::PEN_AW'(stpr_pkg::PEN_ROWS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Stage 0: scroll the position, address the tilemap and build the pen row.
    always_comb begin
        wx_sum  = {1'b0, i_pixel_x} + {1'b0, r_scroll_x};
        wy_sum  = {1'b0, i_pixel_y} + {1'b0, r_scroll_y};
        wx      = wx_sum[8:0];
        wy      = wy_sum[8:0];
        idx_ext = {1'b0, i_index};
        for (int x = 0; x < 8; x++) begin
            pen_row[2*x +: 2] = {i_plane_high[7-x], i_plane_low[7-x]};
        end
    end

    always_comb begin
        tm_we    = r_clr_busy || (accept && i_command == stpr_pkg::CMD_WR_MAP);
        tm_wdata = r_clr_busy ? 16'h0000 : i_data;
        if (r_clr_busy) begin
            tm_addr = r_clr_addr[stpr_pkg::MAP_AW-1:0];
        end else if (i_command == stpr_pkg::CMD_RENDER) begin
            tm_addr = {wy[8:3], wx[8:3]};
        end else begin
            tm_addr = i_index[stpr_pkg::MAP_AW-1:0];
        end
    end

    stpr_ram #(
        .WIDTH(16),
        .DEPTH(stpr_pkg::MAP_WORDS)
    ) u_tilemap (
        .i_clk  (i_clk),
        .i_we   (tm_we),
        .i_addr (tm_addr),
        .i_wdata(tm_wdata),
        .o_rdata(tm_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else begin
            r_p1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1.cmd     <= i_command;
        r_p1.idx     <= i_index;
        r_p1.row     <= i_row;
        r_p1.data    <= i_data;
        r_p1.pens    <= pen_row;
        r_p1.tile_ok <= idx_ext < 13'(stpr_pkg::TILE_COUNT);
        r_p1.lo_x    <= wx[2:0];
        r_p1.lo_y    <= wy[2:0];
    end

    // Stage 1: tile code from the map word, then the tile pen memory.
    always_comb begin
        look     = stpr_pkg::f_lookup({r_bank, tm_rdata[14:8]});
        code_sum = {1'b0, stpr_pkg::CODE_TAB[look[7:0]]}
                 + stpr_pkg::CODE_SUM_W'(tm_rdata[7:0]);
        if (code_sum >= stpr_pkg::CODE_SUM_W'(stpr_pkg::TILE_COUNT)) begin
            code_sum = code_sum - stpr_pkg::CODE_SUM_W'(stpr_pkg::TILE_COUNT);
        end
        code = code_sum[stpr_pkg::CODE_W-1:0];
        base = stpr_pkg::PAL_ORIGIN + stpr_pkg::PAL_AW'({look[15:12], 2'b00});
    end

    always_comb begin
        pen_we    = r_clr_busy
                 || (r_p1_vld && r_p1.cmd == stpr_pkg::CMD_LOAD && r_p1.tile_ok);
        pen_wdata = r_clr_busy ? 16'h0000 : r_p1.pens;
        if (r_clr_busy) begin
            pen_addr = r_clr_addr;
        end else if (r_p1.cmd == stpr_pkg::CMD_LOAD) begin
            pen_addr = {r_p1.idx[stpr_pkg::CODE_W-1:0], r_p1.row};
        end else begin
            pen_addr = {code, r_p1.lo_y};
        end
    end

    stpr_ram #(
        .WIDTH(16),
        .DEPTH(stpr_pkg::PEN_ROWS)
    ) u_pens (
        .i_clk  (i_clk),
        .i_we   (pen_we),
        .i_addr (pen_addr),
        .i_wdata(pen_wdata),
        .o_rdata(pen_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else begin
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2.cmd     <= r_p1.cmd;
        r_p2.pal_idx <= r_p1.idx[stpr_pkg::PAL_AW-1:0];
        r_p2.data    <= r_p1.data;
        r_p2.lo_x    <= r_p1.lo_x;
        r_p2.base    <= base;
    end

    // Stage 2: pick the pen and access the palette.
    always_comb begin
        pen       = pen_rdata[{r_p2.lo_x, 1'b0} +: 2];
        pal_we    = r_clr_busy || (r_p2_vld && r_p2.cmd == stpr_pkg::CMD_WR_PAL);
        pal_wdata = r_clr_busy ? 24'h000000 :
                    {stpr_pkg::f_boost(r_p2.data[11:8], r_p2.data[15]),
                     stpr_pkg::f_boost(r_p2.data[7:4], r_p2.data[15]),
                     stpr_pkg::f_boost(r_p2.data[3:0], r_p2.data[15])};
        if (r_clr_busy) begin
            pal_addr = r_clr_addr[stpr_pkg::PAL_AW-1:0];
        end else if (r_p2.cmd == stpr_pkg::CMD_WR_PAL) begin
            pal_addr = r_p2.pal_idx;
        end else begin
            pal_addr = r_p2.base + stpr_pkg::PAL_AW'(pen);
        end
    end

    stpr_ram #(
        .WIDTH(24),
        .DEPTH(stpr_pkg::PAL_DEPTH)
    ) u_palette (
        .i_clk  (i_clk),
        .i_we   (pal_we),
        .i_addr (pal_addr),
        .i_wdata(pal_wdata),
        .o_rdata(pal_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_vld <= 1'b0;
        end else begin
            r_p3_vld <= r_p2_vld && r_p2.cmd == stpr_pkg::CMD_RENDER;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p3_pen <= pen;
    end

    // Stage 3: the palette color joins its pen in the result FIFO.
    assign push_data.rgb = pal_rdata;
    assign push_data.pen = r_p3_pen;
    assign fifo_pop      = o_valid && !i_stall;

    stpr_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (r_p3_vld),
        .i_push_data(push_data),
        .i_pop      (fifo_pop),
        .o_valid    (o_valid),
        .o_data     (head),
        .o_count    (fifo_count)
    );

    assign o_pixel_rgb = head.rgb;
    assign o_pixel_pen = head.pen;

endmodule

// File: sv/stpr_checker.sv
// Port-level checker for the playfield renderer, bound to the top level.
`include "scrolled_tilemap_pixel_renderer_assert.svh"

module stpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_command,
    input logic        o_valid,
    input logic        i_stall,
    input logic [23:0] o_pixel_rgb,
    input logic [1:0]  o_pixel_pen
);

    logic render_beat;

    assign render_beat = i_valid && !o_stall && i_command == stpr_pkg::CMD_RENDER;

    `STPR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_pixel_rgb) && $stable(o_pixel_pen))

    `STPR_ASSERT_IMPLY(a_clear_after_reset, i_clk, i_rst_n, $past(!i_rst_n), o_stall)

    `STPR_ASSERT_NEXT(a_no_stray_result, i_clk, i_rst_n, !o_valid && !$past(render_beat, 3), !o_valid)

endmodule

bind scrolled_tilemap_pixel_renderer stpr_checker u_stpr_checker (.*);
